FILE: src/huffman_code_bit_packer_unit_macros.svh
// ----------------------------------------------------------------------------
// Huffman code bit packer: assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_CODE_BIT_PACKER_UNIT_MACROS_SVH
`define HUFFMAN_CODE_BIT_PACKER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HCBP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hcbp assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define HCBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hcbp assertion failed");

`endif

FILE: src/hcbp_pkg.sv
// ----------------------------------------------------------------------------
// Huffman code bit packer package
// Shared constants, codes, state and command types, and helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package hcbp_pkg;

  localparam int SYMBOL_COUNT  = 256;
  localparam int MAX_CODE_BITS = 32;
  localparam int WORD_BITS     = 32;
  localparam int BYTE_BITS     = 8;
  localparam int SYM_W         = 8;
  localparam int SYM_IDX_W     = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int LEN_W         = 6;
  localparam int CODE_LEN_CAP  = (MAX_CODE_BITS < WORD_BITS) ? MAX_CODE_BITS : WORD_BITS;
  localparam int ACC_W         = WORD_BITS + BYTE_BITS;
  localparam int CNT_W         = 6;
  localparam int PCNT_W        = 3;
  localparam int KIND_W        = 2;
  localparam int IN_TDATA_W    = 48;
  localparam int OUT_TDATA_W   = 72;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD   = 2'd0,
    KIND_ENCODE = 2'd1,
    KIND_END    = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MERGE,
    ST_EMIT,
    ST_FLUSH
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;    // write a table entry from the input request
    logic lookup;  // register a table read for the input symbol
    logic merge;   // join the code word with the pending bits
    logic emit;    // send one completed byte
    logic settle;  // keep the leftover bits as the pending byte
    logic flush;   // send the end-of-block result and clear the block
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic len_zero;  // looked-up symbol has no code bits
    logic cnt_ge8;   // at least one full byte is collected
    logic out_free;  // output register can take a result this cycle
  } sts_t;

  function automatic logic [WORD_BITS-1:0] sat_add(input logic [WORD_BITS-1:0] a,
                                                   input logic [WORD_BITS-1:0] b);
    logic [WORD_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WORD_BITS] ? {WORD_BITS{1'b1}} : s[WORD_BITS-1:0];
  endfunction

  function automatic logic [WORD_BITS-1:0] code_mask(input logic [LEN_W-1:0] len);
    logic [WORD_BITS-1:0] m;
    if (len >= LEN_W'(WORD_BITS)) begin
      m = {WORD_BITS{1'b1}};
    end else begin
      m = ~({WORD_BITS{1'b1}} << len);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

FILE: src/hcbp_ctrl.sv
// ----------------------------------------------------------------------------
// Huffman code bit packer controller
// Sequences table loads, lookups, byte emission and block flushes.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [hcbp_pkg::KIND_W-1:0]   in_kind,
  input  wire hcbp_pkg::sts_t                sts,
  output hcbp_pkg::cmd_t                     cmd
);

  hcbp_pkg::state_t state_r;
  hcbp_pkg::state_t state_nxt;
  logic             accept;

  assign in_tready = (state_r == hcbp_pkg::ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hcbp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hcbp_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_kind == hcbp_pkg::KIND_ENCODE) begin
            state_nxt = hcbp_pkg::ST_MERGE;
          end else if (in_kind == hcbp_pkg::KIND_END) begin
            state_nxt = hcbp_pkg::ST_FLUSH;
          end
        end
      end
      hcbp_pkg::ST_MERGE: begin
        state_nxt = sts.len_zero ? hcbp_pkg::ST_IDLE : hcbp_pkg::ST_EMIT;
      end
      hcbp_pkg::ST_EMIT: begin
        if (!sts.cnt_ge8) begin
          state_nxt = hcbp_pkg::ST_IDLE;
        end
      end
      hcbp_pkg::ST_FLUSH: begin
        if (sts.out_free) begin
          state_nxt = hcbp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = hcbp_pkg::ST_IDLE;
    endcase
  end

  // Commands.
  always_comb begin
    cmd        = '0;
    cmd.load   = accept && (in_kind == hcbp_pkg::KIND_LOAD);
    cmd.lookup = accept && (in_kind == hcbp_pkg::KIND_ENCODE);
    unique case (state_r)
      hcbp_pkg::ST_IDLE:  ;
      hcbp_pkg::ST_MERGE: cmd.merge = 1'b1;
      hcbp_pkg::ST_EMIT: begin
        cmd.emit   = sts.cnt_ge8 && sts.out_free;
        cmd.settle = !sts.cnt_ge8;
      end
      hcbp_pkg::ST_FLUSH: cmd.flush = sts.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: src/hcbp_datapath.sv
// ----------------------------------------------------------------------------
// Huffman code bit packer datapath
// Code and length tables, bit accumulator, block totals and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_datapath (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire hcbp_pkg::cmd_t                        cmd,
  output hcbp_pkg::sts_t                             sts,
  input  wire logic [hcbp_pkg::SYM_W-1:0]            in_symbol,
  input  wire logic [hcbp_pkg::WORD_BITS-1:0]        in_code_bits,
  input  wire logic [hcbp_pkg::LEN_W-1:0]            in_code_length,
  input  wire logic                                  out_tready,
  output logic                                       out_tvalid,
  output logic [hcbp_pkg::OUT_TDATA_W-1:0]           out_tdata,
  output logic                                       out_tlast,
  output logic                                       out_tuser
);

  localparam int W  = hcbp_pkg::WORD_BITS;
  localparam int BB = hcbp_pkg::BYTE_BITS;

  // Tables.
  logic [W-1:0]                  code_mem [hcbp_pkg::SYMBOL_COUNT];
  logic [hcbp_pkg::LEN_W-1:0]    len_mem  [hcbp_pkg::SYMBOL_COUNT];
  logic [hcbp_pkg::SYMBOL_COUNT-1:0] len_vld_r;

  logic [hcbp_pkg::SYM_IDX_W-1:0] idx;
  logic                           in_range;
  logic [hcbp_pkg::LEN_W-1:0]     len_capped;

  logic [W-1:0]                   rd_code_r;
  logic [hcbp_pkg::LEN_W-1:0]     rd_len_r;
  logic                           rd_vld_r;
  logic [hcbp_pkg::LEN_W-1:0]     eff_len;

  // Bit collection and totals.
  logic [hcbp_pkg::ACC_W-1:0]     acc_r;
  logic [hcbp_pkg::CNT_W-1:0]     cnt_r;
  logic [BB-1:0]                  pending_r;
  logic [hcbp_pkg::PCNT_W-1:0]    pcount_r;
  logic [W-1:0]                   bit_total_r;
  logic [W-1:0]                   byte_total_r;

  // Output register.
  logic                           out_valid_r;
  logic [BB-1:0]                  out_byte_r;
  logic                           out_bvld_r;
  logic                           out_last_r;
  logic [W-1:0]                   out_bits_r;
  logic [W-1:0]                   out_bytes_r;

  assign idx        = in_symbol[hcbp_pkg::SYM_IDX_W-1:0];
  assign in_range   = ({1'b0, in_symbol} < (hcbp_pkg::SYM_W + 1)'(hcbp_pkg::SYMBOL_COUNT));
  assign len_capped = (in_code_length > hcbp_pkg::LEN_W'(hcbp_pkg::CODE_LEN_CAP))
                      ? hcbp_pkg::LEN_W'(hcbp_pkg::CODE_LEN_CAP) : in_code_length;
  assign eff_len    = rd_vld_r ? rd_len_r : '0;

  assign sts.len_zero = (eff_len == '0);
  assign sts.cnt_ge8  = (cnt_r >= hcbp_pkg::CNT_W'(BB));
  assign sts.out_free = !out_valid_r || out_tready;

  // Table write and registered read.
  always_ff @(posedge clk) begin
    if (cmd.load && in_range) begin
      code_mem[idx] <= in_code_bits;
      len_mem[idx]  <= len_capped;
    end
    if (cmd.lookup) begin
      rd_code_r <= code_mem[idx];
      rd_len_r  <= len_mem[idx];
    end
  end

  // Entry valid bits: an entry never loaded reads as length zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (cmd.load && in_range) begin
        len_vld_r[idx] <= 1'b1;
      end
      if (cmd.lookup) begin
        rd_vld_r <= len_vld_r[idx] && in_range;
      end
    end
  end

  // Accumulator: payload, only meaningful between merge and settle.
  always_ff @(posedge clk) begin
    if (cmd.merge) begin
      acc_r <= (hcbp_pkg::ACC_W'(rd_code_r & hcbp_pkg::code_mask(eff_len)) << pcount_r)
               | hcbp_pkg::ACC_W'(pending_r);
      cnt_r <= hcbp_pkg::CNT_W'(pcount_r) + eff_len;
    end else if (cmd.emit) begin
      acc_r <= acc_r >> BB;
      cnt_r <= cnt_r - hcbp_pkg::CNT_W'(BB);
    end
  end

  // Pending byte and block totals.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r    <= '0;
      pcount_r     <= '0;
      bit_total_r  <= '0;
      byte_total_r <= '0;
    end else if (cmd.flush) begin
      pending_r    <= '0;
      pcount_r     <= '0;
      bit_total_r  <= '0;
      byte_total_r <= '0;
    end else begin
      if (cmd.merge && !sts.len_zero) begin
        bit_total_r <= hcbp_pkg::sat_add(bit_total_r, W'(eff_len));
      end
      if (cmd.emit) begin
        byte_total_r <= hcbp_pkg::sat_add(byte_total_r, W'(1));
      end
      if (cmd.settle) begin
        pending_r <= acc_r[BB-1:0];
        pcount_r  <= cnt_r[hcbp_pkg::PCNT_W-1:0];
      end
    end
  end

  // Output register valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit || cmd.flush) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte_r  <= acc_r[BB-1:0];
      out_bvld_r  <= 1'b1;
      out_last_r  <= 1'b0;
      out_bits_r  <= '0;
      out_bytes_r <= '0;
    end else if (cmd.flush) begin
      out_byte_r  <= pending_r;
      out_bvld_r  <= (pcount_r != '0);
      out_last_r  <= 1'b1;
      out_bits_r  <= bit_total_r;
      out_bytes_r <= (pcount_r != '0) ? hcbp_pkg::sat_add(byte_total_r, W'(1))
                                      : byte_total_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_bytes_r, out_bits_r, out_byte_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_bvld_r;

endmodule

`default_nettype wire

FILE: src/huffman_code_bit_packer_unit.sv
// ----------------------------------------------------------------------------
// Huffman code bit packer: top level
// Table-driven Huffman encoder that packs code bits into bytes.
// ----------------------------------------------------------------------------
// Usage. Requests arrive on the in_ stream. in_tuser selects the kind: load a
// table entry, encode a symbol, or end the block. A load stores the code word
// and its length (capped at 32) for one symbol; symbols never loaded emit
// nothing. An encode looks up the symbol and appends its code, bit 0 first,
// to a bit stream packed least significant bit first into bytes. Each full
// byte leaves on the out_ stream with out_tuser (byte valid) high. An end
// request sends one result with out_tlast high that carries any zero-padded
// partial byte and the saturating bit and byte totals of the block, which
// then clear.
// Sequence. A load writes its table entry as it is taken. An encode makes
// 0 to 4 output bytes in order: the registered table read, the merge of the
// code with the pending bits, an emit step per byte, and a step that keeps
// the leftover bits; an unused symbol ends after the merge. The first byte
// reaches the output register after the table read and the merge. An end
// sends its result once the output register is free. One request is in
// progress at a time; the single table read port and the byte-per-cycle
// shifter set the rate. At reset the length valid bits, pending bits, totals
// and the output valid flag clear. When the receiver stalls, the held result
// waits in the output register and byte emission pauses until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_code_bit_packer_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // in_tdata: symbol [7:0], code_bits [39:8], code_length [45:40], zero [47:46]
  input  wire logic [hcbp_pkg::IN_TDATA_W-1:0]     in_tdata,
  // in_tuser: kind [1:0]
  input  wire logic [hcbp_pkg::KIND_W-1:0]         in_tuser,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // out_tdata: packed_byte [7:0], total_bit_count [39:8], total_byte_count [71:40]
  output logic [hcbp_pkg::OUT_TDATA_W-1:0]         out_tdata,
  // out_tlast: block_end
  output logic                                     out_tlast,
  // out_tuser: byte_valid
  output logic                                     out_tuser
);

  hcbp_pkg::cmd_t cmd;
  hcbp_pkg::sts_t sts;

  // Field split of the request payload.
  logic [hcbp_pkg::SYM_W-1:0]     in_symbol;
  logic [hcbp_pkg::WORD_BITS-1:0] in_code_bits;
  logic [hcbp_pkg::LEN_W-1:0]     in_code_length;

  assign in_symbol      = in_tdata[7:0];
  assign in_code_bits   = in_tdata[39:8];
  assign in_code_length = in_tdata[45:40];

  hcbp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_kind   (in_tuser),
    .sts       (sts),
    .cmd       (cmd)
  );

  hcbp_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_symbol      (in_symbol),
    .in_code_bits   (in_code_bits),
    .in_code_length (in_code_length),
    .out_tready     (out_tready),
    .out_tvalid     (out_tvalid),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .out_tuser      (out_tuser)
  );

endmodule

`default_nettype wire

FILE: src/hcbp_checker.sv
// ----------------------------------------------------------------------------
// Huffman code bit packer port checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "huffman_code_bit_packer_unit_macros.svh"

module hcbp_checker (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                out_tvalid,
  input wire logic                                out_tready,
  input wire logic [hcbp_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input wire logic                                out_tlast,
  input wire logic                                out_tuser
);

  // A stalled result stays in place.
  `HCBP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser))

  // Byte results inside a block carry no totals.
  `HCBP_ASSERT_SAME(a_mid_no_totals, clk, rst_n, out_tvalid && !out_tlast, out_tdata[71:8] == 64'd0)

  // Only the end result may come without a byte.
  `HCBP_ASSERT_SAME(a_mid_has_byte, clk, rst_n, out_tvalid && !out_tlast, out_tuser)

  // An empty flush sends a zero byte.
  `HCBP_ASSERT_SAME(a_empty_zero, clk, rst_n, out_tvalid && !out_tuser, out_tdata[7:0] == 8'd0)

endmodule

bind huffman_code_bit_packer_unit hcbp_checker u_hcbp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

`default_nettype wire

FILE: verif/tb_huffman_code_bit_packer_unit.sv
// ----------------------------------------------------------------------------
// Huffman code bit packer: testbench
// Sends table loads, symbol encodes and end-of-block requests, predicts every
// packed byte and block summary in a behavioral model, and checks the output
// stream in order, with random idle cycles on both sides of the block.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_huffman_code_bit_packer_unit;

  localparam logic [hcbp_pkg::KIND_W-1:0] KIND_RESERVED = 2'd3;
  localparam int CODE_CAP   = 32;
  localparam int IDLE_PCT   = 29;
  localparam int SETTLE_CYC = 20;

  // One result as it leaves the out_ stream.
  typedef struct {
    logic [7:0]  data_byte;
    logic        byte_valid;
    logic        block_end;
    logic [31:0] bit_count;
    logic [31:0] byte_count;
  } packed_result_t;

  logic                                clk = 1'b0;
  logic                                rst_n;
  logic                                in_tvalid;
  logic                                in_tready;
  logic [hcbp_pkg::IN_TDATA_W-1:0]     in_tdata;
  logic [hcbp_pkg::KIND_W-1:0]         in_tuser;
  logic                                out_tvalid;
  logic                                out_tready;
  logic [hcbp_pkg::OUT_TDATA_W-1:0]    out_tdata;
  logic                                out_tlast;
  logic                                out_tuser;

  // Shadow of the block state.
  logic [31:0] shadow_code [256];
  logic [5:0]  shadow_len  [256];
  logic [7:0]  carry_byte;
  logic [2:0]  carry_count;
  logic [31:0] block_bits;
  logic [31:0] block_bytes;

  packed_result_t expected_results [$];
  logic [7:0]     loaded_symbols [$];
  int             mismatches;
  bit             no_idle;
  packed_result_t seen;
  packed_result_t want;

  huffman_code_bit_packer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] add_clamped(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // Applies one accepted request to the shadow state and queues its results.
  task automatic predict_packing(input logic [1:0] kind, input logic [7:0] sym,
                                 input logic [31:0] code, input logic [5:0] len);
    logic [63:0]    acc;
    int             clen;
    int             cnt;
    int             n;
    packed_result_t r;
    if (kind == hcbp_pkg::KIND_LOAD) begin
      shadow_code[sym] = code;
      shadow_len[sym]  = (len > CODE_CAP) ? 6'(CODE_CAP) : len;
    end else if (kind == hcbp_pkg::KIND_ENCODE) begin
      clen = shadow_len[sym];
      if (clen != 0) begin
        acc = {32'b0, shadow_code[sym]} & ((64'h1 << clen) - 64'h1);
        acc = (acc << carry_count) | {56'b0, carry_byte};
        cnt = carry_count + clen;
        block_bits = add_clamped(block_bits, 32'(clen));
        n = 0;
        while (cnt >= 8 && n < 4) begin
          r = '{acc[7:0], 1'b1, 1'b0, 32'b0, 32'b0};
          expected_results.push_back(r);
          block_bytes = add_clamped(block_bytes, 32'd1);
          acc = acc >> 8;
          cnt -= 8;
          n++;
        end
        carry_byte  = acc[7:0];
        carry_count = 3'(cnt);
      end
    end else if (kind == hcbp_pkg::KIND_END) begin
      if (carry_count != 0) begin
        // A partly filled byte goes out zero-padded and counts as a byte.
        block_bytes = add_clamped(block_bytes, 32'd1);
        r = '{carry_byte, 1'b1, 1'b1, block_bits, block_bytes};
      end else begin
        r = '{8'b0, 1'b0, 1'b1, block_bits, block_bytes};
      end
      expected_results.push_back(r);
      carry_byte  = '0;
      carry_count = '0;
      block_bits  = '0;
      block_bytes = '0;
    end
  endtask

  // Drives one request at a falling edge and waits for the handshake.
  task automatic send_request(input logic [1:0] kind, input logic [7:0] sym,
                              input logic [31:0] code, input logic [5:0] len);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {2'b00, len, code, sym};
    do @(posedge clk); while (in_tready !== 1'b1);
    predict_packing(kind, sym, code, len);
  endtask

  // Holds the input idle until every predicted result has been taken.
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Mostly short codes so bytes fill at varied offsets, some full width,
  // some above the cap, and a few empty ones.
  function automatic logic [5:0] pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 6'($urandom_range(12, 1));
    if (r < 85) return 6'($urandom_range(32, 13));
    if (r < 95) return 6'($urandom_range(63, 33));
    return 6'd0;
  endfunction

  task automatic load_symbol(input logic [7:0] sym);
    logic [5:0] len;
    len = pick_length();
    send_request(hcbp_pkg::KIND_LOAD, sym, $urandom, len);
    if (len != 0) loaded_symbols.push_back(sym);
  endtask

  // One random request, weighted toward encodes of loaded symbols.
  task automatic random_request();
    int         r;
    logic [7:0] sym;
    r = $urandom_range(99);
    if (r < 12) begin
      load_symbol(8'($urandom));
    end else if (r < 80) begin
      if (loaded_symbols.size() != 0 && $urandom_range(99) < 85) begin
        sym = loaded_symbols[$urandom_range(loaded_symbols.size() - 1)];
      end else begin
        sym = 8'($urandom);
      end
      send_request(hcbp_pkg::KIND_ENCODE, sym, $urandom, 6'($urandom));
    end else if (r < 93) begin
      send_request(hcbp_pkg::KIND_END, 8'($urandom), $urandom, 6'($urandom));
    end else begin
      send_request(KIND_RESERVED, 8'($urandom), $urandom, 6'($urandom));
    end
  endtask

  // An end request with nothing collected yet reports an empty block.
  task automatic test_empty_flush();
    send_request(hcbp_pkg::KIND_END, 8'h00, 32'h0, 6'd0);
    drain_results();
  endtask

  // Symbols never loaded, or loaded with no bits, and the reserved kind all
  // leave the stream untouched.
  task automatic test_silent_requests();
    send_request(hcbp_pkg::KIND_ENCODE, 8'h5A, 32'hFFFF_FFFF, 6'd63);
    send_request(KIND_RESERVED, 8'hFF, 32'hFFFF_FFFF, 6'd63);
    send_request(hcbp_pkg::KIND_LOAD, 8'h03, 32'h1234_5678, 6'd0);
    send_request(hcbp_pkg::KIND_ENCODE, 8'h03, 32'h0, 6'd0);
    send_request(hcbp_pkg::KIND_END, 8'h00, 32'h0, 6'd0);
    drain_results();
  endtask

  // Widest codes on top of pending bits give four bytes per encode; lengths
  // above the cap are clipped, and the block ends once partly filled and
  // once on a byte boundary.
  task automatic test_code_extremes();
    send_request(hcbp_pkg::KIND_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd32);
    send_request(hcbp_pkg::KIND_LOAD, 8'hFF, 32'h0000_0000, 6'd63);
    send_request(hcbp_pkg::KIND_LOAD, 8'h01, 32'hAAAA_AAAB, 6'd1);
    send_request(hcbp_pkg::KIND_LOAD, 8'h02, 32'h0000_0005, 6'd3);
    send_request(hcbp_pkg::KIND_LOAD, 8'h80, 32'h5A5A_C33C, 6'd33);
    send_request(hcbp_pkg::KIND_ENCODE, 8'h02, 32'h0, 6'd0);
    send_request(hcbp_pkg::KIND_ENCODE, 8'h00, 32'h0, 6'd0);
    send_request(hcbp_pkg::KIND_ENCODE, 8'hFF, 32'h0, 6'd0);
    send_request(hcbp_pkg::KIND_ENCODE, 8'h01, 32'h0, 6'd0);
    send_request(hcbp_pkg::KIND_ENCODE, 8'h80, 32'h0, 6'd0);
    send_request(hcbp_pkg::KIND_END, 8'h00, 32'h0, 6'd0);
    send_request(hcbp_pkg::KIND_ENCODE, 8'h00, 32'h0, 6'd0);
    send_request(hcbp_pkg::KIND_END, 8'h00, 32'h0, 6'd0);
    drain_results();
    loaded_symbols = '{8'h00, 8'hFF, 8'h01, 8'h02, 8'h80};
  endtask

  // Fill the table, then a long random stream; the sender stops halfway
  // until the output has caught up.
  task automatic test_random_stream(input int count);
    repeat (24) load_symbol(8'($urandom));
    repeat (count / 2) random_request();
    drain_results();
    repeat (count - count / 2) random_request();
    drain_results();
  endtask

  // Neither side idles, so requests and results move back to back.
  task automatic test_back_to_back(input int count);
    no_idle = 1'b1;
    repeat (count) random_request();
    drain_results();
    no_idle = 1'b0;
  endtask

  always @(negedge clk) begin
    out_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen = '{out_tdata[7:0], out_tuser, out_tlast, out_tdata[39:8], out_tdata[71:40]};
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, actual byte %h valid %b end %b bits %0d bytes %0d",
                 $time, seen.data_byte, seen.byte_valid, seen.block_end,
                 seen.bit_count, seen.byte_count);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (seen.data_byte !== want.data_byte) begin
          $display("%0t: packed_byte expected %h actual %h", $time,
                   want.data_byte, seen.data_byte);
          mismatches++;
        end
        if (seen.byte_valid !== want.byte_valid) begin
          $display("%0t: byte_valid expected %b actual %b", $time,
                   want.byte_valid, seen.byte_valid);
          mismatches++;
        end
        if (seen.block_end !== want.block_end) begin
          $display("%0t: block_end expected %b actual %b", $time,
                   want.block_end, seen.block_end);
          mismatches++;
        end
        if (seen.bit_count !== want.bit_count) begin
          $display("%0t: total_bit_count expected %0d actual %0d", $time,
                   want.bit_count, seen.bit_count);
          mismatches++;
        end
        if (seen.byte_count !== want.byte_count) begin
          $display("%0t: total_byte_count expected %0d actual %0d", $time,
                   want.byte_count, seen.byte_count);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = hcbp_pkg::KIND_LOAD;
    out_tready  = 1'b0;
    no_idle     = 1'b0;
    mismatches  = 0;
    carry_byte  = '0;
    carry_count = '0;
    block_bits  = '0;
    block_bytes = '0;
    for (int i = 0; i < 256; i++) begin
      shadow_code[i] = '0;
      shadow_len[i]  = '0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_flush();
    test_silent_requests();
    test_code_extremes();
    test_random_stream(110);
    test_back_to_back(40);

    repeat (SETTLE_CYC) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Far beyond the slowest passing run, even with long stalls on both sides.
  initial begin
    #3000000;
    $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+src
src/hcbp_pkg.sv
src/hcbp_ctrl.sv
src/hcbp_datapath.sv
src/huffman_code_bit_packer_unit.sv
src/hcbp_checker.sv
verif/tb_huffman_code_bit_packer_unit.sv
